/* hdl/kmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kmd_pkg
// Fixed field widths and reset constants of the key matrix debouncer.
// ---------------------------------------------------------------------------
package kmd_pkg;

  // Field widths fixed by the item format
  localparam int ROW_W = 3;
  localparam int LVL_W = 16;
  localparam int CFG_W = 8;

  // Debounce setting after reset, in scan ticks
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd5;

endpackage : kmd_pkg
`default_nettype wire

/* hdl/kmd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// kmd_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read; a read of the address being written returns old data.
// ---------------------------------------------------------------------------
module kmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : kmd_ram
`default_nettype wire

/* hdl/key_matrix_debouncer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// key_matrix_debouncer
// Per-key deferred debounce for a scanned key matrix, row state in a RAM.
// ---------------------------------------------------------------------------
// Each transfer on the in_ channel carries one row's raw column levels; with
// in_scan_start set the wrapping scan tick advances before the row is
// handled. A key whose raw level differs from its last sample is stamped
// with the current tick; once the tick has moved more than debounce_ticks
// past the stamp the debounced level follows the raw level and the key is
// flagged in out_changed_mask. One row is taken per clock unless the output
// stalls, and one result per row is returned; the read of the per-row state
// RAM (last raw sample, debounced levels and all key stamps of a row in one
// word) is registered. A row written in the cycle before is forwarded, so
// the same row may follow itself directly. Row state starts at zero through
// per-row valid bits, so there is no clearing pass after reset. Rows at or
// beyond ROWS leave the state alone and report zero levels; columns at or
// beyond COLS read as zero. The user must write debounce_ticks through the
// cfg_ channel only while the block idles; the block does not enforce it.
// ---------------------------------------------------------------------------
module key_matrix_debouncer #(
  parameter int ROWS      = 8,
  parameter int COLS      = 16,
  parameter int TICK_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration write channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [kmd_pkg::CFG_W-1:0]    cfg_debounce_ticks,
  // row input channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [kmd_pkg::ROW_W-1:0]    in_row_index,
  input  wire logic [kmd_pkg::LVL_W-1:0]    in_column_levels,
  input  wire logic                         in_scan_start,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [kmd_pkg::ROW_W-1:0]    out_row_out,
  output logic      [kmd_pkg::LVL_W-1:0]    out_debounced_levels,
  output logic      [kmd_pkg::LVL_W-1:0]    out_changed_mask,
  output logic                              out_any_change
);

  import kmd_pkg::*;

  // Active columns, address width and RAM word layout:
  // {stamps[ACT*TICK_BITS], debounced[ACT], last_raw[ACT]}
  localparam int ACT   = (COLS < LVL_W) ? COLS : LVL_W;
  localparam int AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int STW   = ACT * TICK_BITS;
  localparam int MEM_W = STW + 2 * ACT;

  // -------------------------------------------------------------------------
  // Configuration register
  // -------------------------------------------------------------------------
  logic [CFG_W-1:0] debounce_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      debounce_ticks_r <= cfg_debounce_ticks;
    end
  end

  // -------------------------------------------------------------------------
  // Handshake: the pipeline advances whenever the output register is free
  // or its result is being taken in this cycle.
  // -------------------------------------------------------------------------
  logic in_accept;
  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign in_accept = in_valid && in_ready;

  // -------------------------------------------------------------------------
  // Stage 0: advance the tick, issue the row state read
  // -------------------------------------------------------------------------
  logic [TICK_BITS-1:0] tick_r;
  logic [TICK_BITS-1:0] tick_nxt;
  logic                 in_range;
  logic [AW-1:0]        rd_addr;

  assign tick_nxt = (in_accept && in_scan_start) ? tick_r + TICK_BITS'(1) : tick_r;
  assign in_range = (32'(in_row_index) < ROWS);
  // Park the read address on row 0 for rows outside the matrix
  assign rd_addr  = in_range ? AW'(in_row_index) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else begin
      tick_r <= tick_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1 registers: the item whose row state the RAM is returning
  // -------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_in_range_r;
  logic [ACT-1:0]       s1_raw_r;
  logic [TICK_BITS-1:0] s1_tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_row_r      <= in_row_index;
      s1_addr_r     <= rd_addr;
      s1_in_range_r <= in_range;
      s1_raw_r      <= in_column_levels[ACT-1:0];
      s1_tick_r     <= tick_nxt;
    end
  end

  // -------------------------------------------------------------------------
  // Row state RAM, valid bits and write forwarding
  // -------------------------------------------------------------------------
  logic             wr_en;
  logic [MEM_W-1:0] wr_data;
  logic [MEM_W-1:0] mem_q;
  logic [ROWS-1:0]  row_valid_r;
  logic             fwd_valid_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [MEM_W-1:0] fwd_data_r;
  logic [MEM_W-1:0] cur_rec;

  kmd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (mem_q)
  );

  // Write back as the item leaves stage 1
  assign wr_en = s1_valid_r && adv && s1_in_range_r;

  // Mark rows written since reset; hold the latest write for forwarding.
  // The latest write is always the newest copy of its row, so it may be
  // forwarded for as long as it is held.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      fwd_valid_r <= 1'b0;
    end else if (wr_en) begin
      row_valid_r[s1_addr_r] <= 1'b1;
      fwd_valid_r            <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= wr_data;
    end
  end

  always_comb begin
    if (fwd_valid_r && (fwd_addr_r == s1_addr_r)) begin
      cur_rec = fwd_data_r;
    end else if (row_valid_r[s1_addr_r]) begin
      cur_rec = mem_q;
    end else begin
      cur_rec = '0;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1 update: all columns of the row in parallel
  // -------------------------------------------------------------------------
  logic [ACT-1:0] prev_raw;
  logic [ACT-1:0] deb_old;
  logic [STW-1:0] stamp_old;
  logic [STW-1:0] stamp_new;
  logic [STW-1:0] age;
  logic [ACT-1:0] deb_new;
  logic [ACT-1:0] chg;

  assign prev_raw  = cur_rec[ACT-1:0];
  assign deb_old   = cur_rec[2*ACT-1:ACT];
  assign stamp_old = cur_rec[MEM_W-1:2*ACT];

  always_comb begin
    stamp_new = stamp_old;
    age       = '0;
    deb_new   = deb_old;
    chg       = '0;
    for (int c = 0; c < ACT; c++) begin
      // Restamp a key whose raw level moved
      if (s1_raw_r[c] != prev_raw[c]) begin
        stamp_new[c*TICK_BITS +: TICK_BITS] = s1_tick_r;
      end
      age[c*TICK_BITS +: TICK_BITS] = s1_tick_r - stamp_new[c*TICK_BITS +: TICK_BITS];
      // Follow the raw level once it has been stable long enough
      if ((age[c*TICK_BITS +: TICK_BITS] > TICK_BITS'(debounce_ticks_r)) &&
          (deb_old[c] != s1_raw_r[c])) begin
        deb_new[c] = s1_raw_r[c];
        chg[c]     = 1'b1;
      end
    end
  end

  assign wr_data = {stamp_new, deb_new, s1_raw_r};

  // -------------------------------------------------------------------------
  // Output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_row_out <= s1_row_r;
      if (s1_in_range_r) begin
        out_debounced_levels <= LVL_W'(deb_new);
        out_changed_mask     <= LVL_W'(chg);
        out_any_change       <= |chg;
      end else begin
        // Drop rows outside the matrix: report nothing
        out_debounced_levels <= '0;
        out_changed_mask     <= '0;
        out_any_change       <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // An accepted row always reaches stage 1 on the next edge
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted row did not reach stage 1");

  // A write-back marks its row as holding valid state
  a_write_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> row_valid_r[$past(s1_addr_r)])
    else $error("row valid bit not set after write-back");

  // Rows outside the matrix report zero levels and no change
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (32'(out_row_out) >= ROWS)) |->
      ((out_debounced_levels == '0) && (out_changed_mask == '0) && !out_any_change))
    else $error("row outside the matrix reported key state");

  // The change flag agrees with the change mask on every result
  a_any_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_any_change == (out_changed_mask != '0)))
    else $error("any_change disagrees with changed_mask");

endmodule : key_matrix_debouncer
`default_nettype wire

/* test/key_matrix_debouncer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_matrix_debouncer_tb
// Self-checking bench for the per-key scanned matrix debouncer.
// ---------------------------------------------------------------------------
// Rows are sent over the in_ channel in random bursts while the result side
// stalls on its own pattern. A behavioural copy of the debounce state
// (scan tick, last raw sample, debounced levels and per-key stamps) predicts
// each result at the input transfer, and a checker compares every result
// transfer with the oldest prediction. Directed tests cover the reset
// setting, every row and level extreme, rows without a tick advance, and a
// long hold with one early bounce at the slowest setting; random scans with
// key bounce follow at several settings.
// ---------------------------------------------------------------------------
module key_matrix_debouncer_tb;
  import kmd_pkg::*;

  localparam int NUM_ROWS  = 8;
  localparam int NUM_COLS  = 16;
  localparam int TICK_W    = 16;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [LVL_W-1:0] levels;
    logic [LVL_W-1:0] changed;
    logic             any_change;
  } row_result_t;

  logic clk;
  logic rst_n = 1'b0;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_debounce_ticks = '0;

  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [ROW_W-1:0] in_row_index = '0;
  logic [LVL_W-1:0] in_column_levels = '0;
  logic             in_scan_start = 1'b0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ROW_W-1:0] out_row_out;
  logic [LVL_W-1:0] out_debounced_levels;
  logic [LVL_W-1:0] out_changed_mask;
  logic             out_any_change;

  // Predicted debounce state, mirrors the block's row RAM and tick counter
  logic [TICK_W-1:0] tick_count;
  logic [LVL_W-1:0]  raw_history   [NUM_ROWS];
  logic [LVL_W-1:0]  stable_levels [NUM_ROWS];
  logic [TICK_W-1:0] key_stamp     [NUM_ROWS][NUM_COLS];
  logic [CFG_W-1:0]  hold_ticks;

  row_result_t pending_rows[$];
  int          error_count = 0;
  int          burst_left = 0;

  // Receiver stall pattern
  int          stall_mode = 0;
  int          stall_window = 0;

  key_matrix_debouncer #(
    .ROWS      (NUM_ROWS),
    .COLS      (NUM_COLS),
    .TICK_BITS (TICK_W)
  ) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_debounce_ticks   (cfg_debounce_ticks),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_row_index         (in_row_index),
    .in_column_levels     (in_column_levels),
    .in_scan_start        (in_scan_start),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_row_out          (out_row_out),
    .out_debounced_levels (out_debounced_levels),
    .out_changed_mask     (out_changed_mask),
    .out_any_change       (out_any_change)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit, many times the slowest legal run under the heaviest stalls
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Advance the debounce state by one row and return the result it yields.
  // All rows of a 3-bit index exist here, so the out-of-range path never
  // applies.
  function automatic row_result_t debounce_row(input logic [ROW_W-1:0] r,
                                               input logic [LVL_W-1:0] lv,
                                               input logic st);
    logic [LVL_W-1:0]  prev;
    logic [LVL_W-1:0]  deb;
    logic [LVL_W-1:0]  chg;
    logic [TICK_W-1:0] age;
    row_result_t       res;
    prev = raw_history[r];
    deb  = stable_levels[r];
    chg  = '0;
    if (st) begin
      tick_count = tick_count + 1'b1;
    end
    for (int c = 0; c < NUM_COLS; c++) begin
      if (lv[c] != prev[c]) begin
        key_stamp[r][c] = tick_count;
      end
      // modular age: the subtraction wraps at the tick width
      age = tick_count - key_stamp[r][c];
      if (age > TICK_W'(hold_ticks) && deb[c] != lv[c]) begin
        deb[c] = lv[c];
        chg[c] = 1'b1;
      end
    end
    stable_levels[r] = deb;
    raw_history[r]   = lv;
    res.row        = r;
    res.levels     = deb;
    res.changed    = chg;
    res.any_change = |chg;
    return res;
  endfunction

  // Receiver: pick a stall mode per window, including windows with no stalls
  always @(posedge clk) begin
    if (stall_window == 0) begin
      stall_mode   <= $urandom_range(0, 3);
      stall_window <= $urandom_range(16, 96);
    end else begin
      stall_window <= stall_window - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_window[2];
    endcase
  end

  // Checker: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    row_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_rows.size() == 0) begin
        $error("result for row %0d arrived with nothing pending", out_row_out);
        error_count++;
      end else begin
        want = pending_rows.pop_front();
        if (out_row_out !== want.row) begin
          $error("row_out: expected %0d, got %0d", want.row, out_row_out);
          error_count++;
        end
        if (out_debounced_levels !== want.levels) begin
          $error("debounced_levels: expected %h, got %h", want.levels,
                 out_debounced_levels);
          error_count++;
        end
        if (out_changed_mask !== want.changed) begin
          $error("changed_mask: expected %h, got %h", want.changed, out_changed_mask);
          error_count++;
        end
        if (out_any_change !== want.any_change) begin
          $error("any_change: expected %0d, got %0d", want.any_change,
                 out_any_change);
          error_count++;
        end
      end
    end
  end

  // Send one row; hold valid and payload until the transfer, then predict.
  // Valid is left high on return so a following row can go straight out.
  task automatic send_row(input logic [ROW_W-1:0] r, input logic [LVL_W-1:0] lv,
                          input logic st);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid         <= 1'b1;
    in_row_index     <= r;
    in_column_levels <= lv;
    in_scan_start    <= st;
    do @(posedge clk); while (!in_ready);
    pending_rows.push_back(debounce_row(r, lv, st));
    burst_left--;
  endtask

  // Drop valid, drain every pending result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write debounce_ticks; only called while the block is idle
  task automatic write_hold_ticks(input logic [CFG_W-1:0] v);
    cfg_valid          <= 1'b1;
    cfg_debounce_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    hold_ticks = v;
  endtask

  // Reset setting: a full-row press is accepted on the sixth tick after it
  task automatic test_reset_setting();
    send_row(3'd0, 16'hFFFF, 1'b1);
    send_row(3'd0, 16'hFFFF, 1'b0);
    repeat (6) send_row(3'd0, 16'hFFFF, 1'b1);
    send_row(3'd0, 16'h0000, 1'b1);
    wait_idle();
  endtask

  // Every row with level extremes, twice over, at the fastest setting;
  // the same row back to back exercises the forwarding path
  task automatic test_rows_extremes();
    logic [LVL_W-1:0] pat [NUM_ROWS];
    write_hold_ticks(8'd0);
    pat = '{16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001,
            16'h8000, 16'h00FF, 16'hFF00, 16'h0000};
    for (int r = 0; r < NUM_ROWS; r++) send_row(r[ROW_W-1:0], pat[r], r == 0);
    for (int r = 0; r < NUM_ROWS; r++) send_row(r[ROW_W-1:0], pat[r], r == 0);
    send_row(3'd5, 16'h7FFE, 1'b1);
    send_row(3'd5, 16'h7FFE, 1'b1);
    send_row(3'd5, 16'h0000, 1'b0);
    wait_idle();
  endtask

  // Without a tick advance the age stays zero and nothing is accepted
  task automatic test_no_advance();
    repeat (4) send_row(3'd1, 16'h1234, 1'b0);
    send_row(3'd1, 16'h1234, 1'b1);
    wait_idle();
  endtask

  // Slowest setting: row 2 changes and holds for 300 ticks, so its keys are
  // taken once the tick is 256 past their stamp; one key bounces back early
  // and restarts its count.
  task automatic test_slow_setting();
    logic [LVL_W-1:0] lv2;
    write_hold_ticks(8'hFF);
    lv2 = raw_history[2] ^ 16'h0F01;
    for (int i = 0; i < 300; i++) begin
      send_row(3'd2, (i == 40) ? (lv2 ^ 16'h0001) : lv2, 1'b1);
    end
    wait_idle();
  endtask

  // Scans of all rows in order with bouncing key changes, mixed with noise
  // rows: random index, random levels, missing or extra tick advances
  task automatic test_random_scans(input logic [CFG_W-1:0] setting,
                                   input int n_items);
    logic [LVL_W-1:0] target [NUM_ROWS];
    logic [LVL_W-1:0] bounce [NUM_ROWS];
    int               bounce_left [NUM_ROWS];
    logic [LVL_W-1:0] lv;
    int               sent;
    write_hold_ticks(setting);
    for (int r = 0; r < NUM_ROWS; r++) begin
      target[r]      = raw_history[r];
      bounce[r]      = '0;
      bounce_left[r] = 0;
    end
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        for (int r = 0; r < NUM_ROWS; r++) begin
          if (bounce_left[r] == 0 && $urandom_range(0, 11) == 0) begin
            bounce[r]      = LVL_W'($urandom & $urandom);
            target[r]      = target[r] ^ bounce[r];
            bounce_left[r] = $urandom_range(0, int'(setting) + 4);
          end
          lv = target[r];
          if (bounce_left[r] > 0) begin
            lv = lv ^ (bounce[r] & LVL_W'($urandom));
            bounce_left[r]--;
          end
          send_row(r[ROW_W-1:0], lv, r == 0);
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_row(ROW_W'($urandom_range(0, NUM_ROWS - 1)), LVL_W'($urandom),
                   1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    tick_count = '0;
    hold_ticks = DEBOUNCE_RESET;
    for (int r = 0; r < NUM_ROWS; r++) begin
      raw_history[r]   = '0;
      stable_levels[r] = '0;
      for (int c = 0; c < NUM_COLS; c++) key_stamp[r][c] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_setting();
    test_rows_extremes();
    test_no_advance();
    test_slow_setting();
    test_random_scans(8'd0, 220);
    test_random_scans(8'd1, 220);
    test_random_scans(CFG_W'($urandom_range(2, 7)), 200);
    test_random_scans(8'd4, 180);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* key_matrix_debouncer.f */
hdl/kmd_pkg.sv
hdl/kmd_ram.sv
hdl/key_matrix_debouncer.sv
test/key_matrix_debouncer_tb.sv
